// ----- rtl/core/double_mod_prefix_hash_engine_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the double-modulus prefix hash engine
// Both expect clk and rst_n in scope; checks are off while in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_MOD_PREFIX_HASH_ENGINE_TOP_MACROS_SVH
`define DOUBLE_MOD_PREFIX_HASH_ENGINE_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DMPH_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DMPH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dmph_pkg.sv -----
// ----------------------------------------------------------------------------
// dmph_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package dmph_pkg;

  localparam int HASH_W      = 30;
  localparam int PROD_W      = 2 * HASH_W;
  localparam int REQ_W       = 2;
  localparam int CHAR_W      = 8;
  localparam int STAT_W      = 2;
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 4;
  localparam int MAX_LEN_DEF = 4096;

  localparam logic [HASH_W-1:0] MOD_A_RST  = HASH_W'(127657753);
  localparam logic [HASH_W-1:0] MOD_B_RST  = HASH_W'(987654319);
  localparam logic [HASH_W-1:0] BASE_A_RST = HASH_W'(137);
  localparam logic [HASH_W-1:0] BASE_B_RST = HASH_W'(277);

  // request kinds
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MOD_A  = 2'd0;
  localparam logic [1:0] REG_MOD_B  = 2'd1;
  localparam logic [1:0] REG_BASE_A = 2'd2;
  localparam logic [1:0] REG_BASE_B = 2'd3;

  // table read address select
  localparam logic [1:0] RD_APPEND = 2'd0;
  localparam logic [1:0] RD_QHI    = 2'd1;
  localparam logic [1:0] RD_QLO    = 2'd2;

  typedef struct packed {
    logic              item_load;
    logic              len_clr;
    logic              len_inc;
    logic              rd_en;
    logic [1:0]        rd_sel;
    logic              lat_hi;
    logic              mul_en;
    logic              mul_app;
    logic              red_start;
    logic              wr_en;
    logic              res_load;
    logic              res_hash;
    logic [STAT_W-1:0] res_status;
  } dmph_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             full;
    logic             range_ok;
    logic             red_busy;
  } dmph_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/double_mod_prefix_hash_engine_top.sv -----
// ----------------------------------------------------------------------------
// double_mod_prefix_hash_engine_top
// One item at a time: a new item is taken only once the result of the last
// is in the output register, and that load waits while out_tvalid is unaccepted.
// The 30 radix-4 steps of the four parallel modular reducers do the reduction.
// Synchronous active-low reset: registers back to defaults, string emptied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_mod_prefix_hash_engine_top_macros.svh"

module double_mod_prefix_hash_engine_top #(
  parameter  int MAX_LEN = dmph_pkg::MAX_LEN_DEF,
  localparam int LEN_W   = $clog2(MAX_LEN + 1),
  localparam int IN_W    = ((dmph_pkg::REQ_W + dmph_pkg::CHAR_W + 2 * LEN_W + 7) / 8) * 8,
  localparam int OUT_W   = ((2 * dmph_pkg::HASH_W + dmph_pkg::STAT_W + LEN_W + 7) / 8) * 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // req_type, char_code, left, right
  input  wire logic [IN_W-1:0]             in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // hash_a, hash_b, status, length
  output logic      [OUT_W-1:0]            out_tdata,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [dmph_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [dmph_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [dmph_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                             cfg_pready
);
  import dmph_pkg::*;

  localparam int CH_LO = REQ_W;
  localparam int L_LO  = REQ_W + CHAR_W;
  localparam int R_LO  = L_LO + LEN_W;

  logic [HASH_W-1:0] mod_a_r, mod_b_r, base_a_r, base_b_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  dmph_cmd_t         cmd;
  dmph_sts_t         sts;
  logic [HASH_W-1:0] res_hash_a, res_hash_b;
  logic [STAT_W-1:0] res_status;
  logic [LEN_W-1:0]  res_length;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_AW-1 -: 2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_a_r  <= MOD_A_RST;
      mod_b_r  <= MOD_B_RST;
      base_a_r <= BASE_A_RST;
      base_b_r <= BASE_B_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MOD_A:  mod_a_r  <= cfg_pwdata[HASH_W-1:0];
        REG_MOD_B:  mod_b_r  <= cfg_pwdata[HASH_W-1:0];
        REG_BASE_A: base_a_r <= cfg_pwdata[HASH_W-1:0];
        REG_BASE_B: base_b_r <= cfg_pwdata[HASH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MOD_A:  cfg_prdata = CFG_DW'(mod_a_r);
      REG_MOD_B:  cfg_prdata = CFG_DW'(mod_b_r);
      REG_BASE_A: cfg_prdata = CFG_DW'(base_a_r);
      REG_BASE_B: cfg_prdata = CFG_DW'(base_b_r);
    endcase
  end

  dmph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  dmph_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (in_tdata[REQ_W-1:0]),
    .char_code (in_tdata[CH_LO +: CHAR_W]),
    .left      (in_tdata[L_LO +: LEN_W]),
    .right     (in_tdata[R_LO +: LEN_W]),
    .mod_a     (mod_a_r),
    .mod_b     (mod_b_r),
    .base_a    (base_a_r),
    .base_b    (base_b_r),
    .hash_a    (res_hash_a),
    .hash_b    (res_hash_b),
    .status    (res_status),
    .length    (res_length)
  );

  assign out_tdata = OUT_W'({res_length, res_status, res_hash_b, res_hash_a});

  `DMPH_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "item taken while busy")
  `DMPH_ASSERT_SAME(a_len_bound, out_tvalid, res_length <= LEN_W'(MAX_LEN), "length past capacity")
  `DMPH_ASSERT_SAME(a_err_zero_hash, out_tvalid && res_status != ST_OK,
                    res_hash_a == '0 && res_hash_b == '0, "hash on a failed item")
  `DMPH_ASSERT_SAME(a_full_len, out_tvalid && res_status == ST_FULL,
                    res_length == LEN_W'(MAX_LEN), "full refusal below capacity")

endmodule

`default_nettype wire

// ----- rtl/core/dmph_ram.sv -----
// ----------------------------------------------------------------------------
// dmph_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dmph_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/dmph_reduce.sv -----
// ----------------------------------------------------------------------------
// dmph_reduce
// Radix-4 restoring reduction of a 60-bit value by a 30-bit modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module dmph_reduce (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [dmph_pkg::PROD_W-1:0] value,
  input  wire logic [dmph_pkg::HASH_W-1:0] modulus,
  output logic                             busy,
  output logic      [dmph_pkg::HASH_W-1:0] result
);
  import dmph_pkg::*;

  localparam int STEPS = PROD_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   sh_r;
  logic [HASH_W-1:0]   rem_r, rem_nxt;
  logic [HASH_W-1:0]   m1_r;
  logic [HASH_W:0]     m2_r;
  logic [HASH_W+1:0]   m3_r;
  logic [HASH_W+1:0]   t;

  // rem < m, so 4*rem + digit < 4*m: at most one of m, 2m, 3m comes off
  assign t = {rem_r, sh_r[PROD_W-1 -: 2]};

  always_comb begin
    priority if (t >= m3_r) begin
      rem_nxt = HASH_W'(t - m3_r);
    end else if (t >= {1'b0, m2_r}) begin
      rem_nxt = HASH_W'(t - {1'b0, m2_r});
    end else if (t >= {2'b00, m1_r}) begin
      rem_nxt = HASH_W'(t - {2'b00, m1_r});
    end else begin
      rem_nxt = HASH_W'(t);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = CW'(STEPS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= value;
      rem_r <= '0;
      m1_r  <= modulus;
      m2_r  <= {modulus, 1'b0};
      m3_r  <= {2'b00, modulus} + {1'b0, modulus, 1'b0};
    end else if (cnt_r != '0) begin
      sh_r  <= {sh_r[PROD_W-3:0], 2'b00};
      rem_r <= rem_nxt;
    end
  end

  assign busy   = (cnt_r != '0);
  assign result = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/dmph_datapath.sv -----
// ----------------------------------------------------------------------------
// dmph_datapath
// Hash/power tables, multipliers, four reducers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmph_datapath #(
  parameter  int MAX_LEN = dmph_pkg::MAX_LEN_DEF,
  localparam int LEN_W   = $clog2(MAX_LEN + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire dmph_pkg::dmph_cmd_t         cmd,
  output dmph_pkg::dmph_sts_t              sts,
  input  wire logic [dmph_pkg::REQ_W-1:0]  req_type,
  input  wire logic [dmph_pkg::CHAR_W-1:0] char_code,
  input  wire logic [LEN_W-1:0]            left,
  input  wire logic [LEN_W-1:0]            right,
  input  wire logic [dmph_pkg::HASH_W-1:0] mod_a,
  input  wire logic [dmph_pkg::HASH_W-1:0] mod_b,
  input  wire logic [dmph_pkg::HASH_W-1:0] base_a,
  input  wire logic [dmph_pkg::HASH_W-1:0] base_b,
  output logic      [dmph_pkg::HASH_W-1:0] hash_a,
  output logic      [dmph_pkg::HASH_W-1:0] hash_b,
  output logic      [dmph_pkg::STAT_W-1:0] status,
  output logic      [LEN_W-1:0]            length
);
  import dmph_pkg::*;

  localparam int DEPTH = MAX_LEN + 1;

  logic [REQ_W-1:0]  req_r;
  logic [CHAR_W-1:0] ch_r;
  logic [LEN_W-1:0]  left_r, right_r;
  logic [LEN_W-1:0]  len_r, len_nxt;

  logic [LEN_W-1:0]  lo_addr, span;
  logic [LEN_W-1:0]  pre_rd_addr, pow_rd_addr;
  logic [PROD_W-1:0] pre_rdata, pow_rdata;
  logic              pre_zero_r, pow_zero_r;
  logic [HASH_W-1:0] pre_q_a, pre_q_b, pow_q_a, pow_q_b;
  logic [HASH_W-1:0] hi_a_r, hi_b_r, pw_a_r, pw_b_r;
  logic [HASH_W-1:0] eff_a, eff_b;

  logic [PROD_W-1:0] prod_r   [4];
  logic [PROD_W-1:0] prod_nxt [4];
  logic [HASH_W-1:0] red_res  [4];
  logic [3:0]        red_busy;

  logic [HASH_W:0]   diff_a, diff_b, fin_a, fin_b;

  logic [HASH_W-1:0] hash_a_r, hash_b_r;
  logic [STAT_W-1:0] status_r;
  logic [LEN_W-1:0]  length_r;

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      req_r   <= req_type;
      ch_r    <= char_code;
      left_r  <= left;
      right_r <= right;
    end
  end

  always_comb begin
    len_nxt = len_r;
    if (cmd.len_clr) begin
      len_nxt = '0;
    end else if (cmd.len_inc) begin
      len_nxt = len_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign sts.req      = req_r;
  assign sts.full     = (len_r >= LEN_W'(MAX_LEN));
  assign sts.range_ok = (left_r != '0) && (left_r <= right_r) && (right_r <= len_r);
  assign sts.red_busy = |red_busy;

  assign lo_addr = left_r - 1'b1;
  assign span    = right_r - left_r + 1'b1;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_APPEND: pre_rd_addr = len_r;
      RD_QHI:    pre_rd_addr = right_r;
      RD_QLO:    pre_rd_addr = lo_addr;
      default:   pre_rd_addr = len_r;
    endcase
  end

  assign pow_rd_addr = (cmd.rd_sel == RD_APPEND) ? len_r : span;

  // slot zero is never written: it reads as prefix 0 and power 1
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      pre_zero_r <= (pre_rd_addr == '0);
      pow_zero_r <= (pow_rd_addr == '0);
    end
  end

  dmph_ram #(.WIDTH(PROD_W), .DEPTH(DEPTH)) u_pre_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (len_r + 1'b1),
    .wr_data ({red_res[3], red_res[1]}),
    .rd_en   (cmd.rd_en),
    .rd_addr (pre_rd_addr),
    .rd_data (pre_rdata)
  );

  dmph_ram #(.WIDTH(PROD_W), .DEPTH(DEPTH)) u_pow_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (len_r + 1'b1),
    .wr_data ({red_res[2], red_res[0]}),
    .rd_en   (cmd.rd_en),
    .rd_addr (pow_rd_addr),
    .rd_data (pow_rdata)
  );

  assign pre_q_a = pre_zero_r ? '0 : pre_rdata[HASH_W-1:0];
  assign pre_q_b = pre_zero_r ? '0 : pre_rdata[PROD_W-1:HASH_W];
  assign pow_q_a = pow_zero_r ? HASH_W'(1) : pow_rdata[HASH_W-1:0];
  assign pow_q_b = pow_zero_r ? HASH_W'(1) : pow_rdata[PROD_W-1:HASH_W];

  always_ff @(posedge clk) begin
    if (cmd.lat_hi) begin
      hi_a_r <= pre_q_a;
      hi_b_r <= pre_q_b;
      pw_a_r <= pow_q_a;
      pw_b_r <= pow_q_b;
    end
  end

  assign eff_a = (mod_a == '0) ? HASH_W'(1) : mod_a;
  assign eff_b = (mod_b == '0) ? HASH_W'(1) : mod_b;

  // units 0/2: next power, or the plain upper prefix of a query
  // units 1/3: next prefix with the new byte, or lower prefix times power
  always_comb begin
    if (cmd.mul_app) begin
      prod_nxt[0] = pow_q_a * base_a;
      prod_nxt[1] = pre_q_a * base_a + PROD_W'(ch_r);
      prod_nxt[2] = pow_q_b * base_b;
      prod_nxt[3] = pre_q_b * base_b + PROD_W'(ch_r);
    end else begin
      prod_nxt[0] = PROD_W'(hi_a_r);
      prod_nxt[1] = pre_q_a * pw_a_r;
      prod_nxt[2] = PROD_W'(hi_b_r);
      prod_nxt[3] = pre_q_b * pw_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_red
    dmph_reduce u_red (
      .clk     (clk),
      .rst_n   (rst_n),
      .start   (cmd.red_start),
      .value   (prod_r[g]),
      .modulus ((g < 2) ? eff_a : eff_b),
      .busy    (red_busy[g]),
      .result  (red_res[g])
    );
  end

  assign diff_a = {1'b0, red_res[0]} - {1'b0, red_res[1]};
  assign diff_b = {1'b0, red_res[2]} - {1'b0, red_res[3]};
  assign fin_a  = diff_a[HASH_W] ? diff_a + {1'b0, eff_a} : diff_a;
  assign fin_b  = diff_b[HASH_W] ? diff_b + {1'b0, eff_b} : diff_b;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      hash_a_r <= cmd.res_hash ? fin_a[HASH_W-1:0] : '0;
      hash_b_r <= cmd.res_hash ? fin_b[HASH_W-1:0] : '0;
      status_r <= cmd.res_status;
      length_r <= len_r;
    end
  end

  assign hash_a = hash_a_r;
  assign hash_b = hash_b_r;
  assign status = status_r;
  assign length = length_r;

endmodule

`default_nettype wire

// ----- rtl/core/dmph_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmph_ctrl
// Sequencer for append, query and clear; owns the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dmph_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire dmph_pkg::dmph_sts_t sts,
  output dmph_pkg::dmph_cmd_t      cmd
);
  import dmph_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_A_RD  = 4'd2;
  localparam logic [3:0] S_A_MUL = 4'd3;
  localparam logic [3:0] S_Q_HI  = 4'd4;
  localparam logic [3:0] S_Q_LO  = 4'd5;
  localparam logic [3:0] S_Q_MUL = 4'd6;
  localparam logic [3:0] S_GO    = 4'd7;
  localparam logic [3:0] S_RED   = 4'd8;
  localparam logic [3:0] S_A_WR  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic              res_hash_r, res_hash_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    res_st_nxt    = res_st_r;
    res_hash_nxt  = res_hash_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.item_load = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        res_hash_nxt = 1'b0;
        res_st_nxt   = ST_OK;
        state_nxt    = S_FIN;
        unique case (sts.req)
          REQ_APPEND: begin
            if (sts.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          REQ_QUERY: begin
            if (!sts.range_ok) begin
              res_st_nxt = ST_RANGE;
            end else begin
              res_hash_nxt = 1'b1;
              state_nxt    = S_Q_HI;
            end
          end
          REQ_CLEAR: cmd.len_clr = 1'b1;
          default: ;
        endcase
      end
      S_A_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_APPEND;
        state_nxt  = S_A_MUL;
      end
      S_A_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_app = 1'b1;
        state_nxt   = S_GO;
      end
      S_Q_HI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_QHI;
        state_nxt  = S_Q_LO;
      end
      S_Q_LO: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_QLO;
        cmd.lat_hi = 1'b1;
        state_nxt  = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_GO;
      end
      S_GO: begin
        cmd.red_start = 1'b1;
        state_nxt     = S_RED;
      end
      S_RED: begin
        if (!sts.red_busy) begin
          state_nxt = (sts.req == REQ_APPEND) ? S_A_WR : S_FIN;
        end
      end
      S_A_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.len_inc = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        // hold here until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = res_st_r;
          cmd.res_hash   = res_hash_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_st_r   <= res_st_nxt;
    res_hash_r <= res_hash_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- tb/double_mod_prefix_hash_engine_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_mod_prefix_hash_engine_top_tb
// Streams append, query and clear requests into the hash engine. Register
// settings change between phases, some of them with a string still stored.
// A scoreboard keeps its own prefix-hash and power tables, predicts every
// result and checks the results in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module double_mod_prefix_hash_engine_top_tb;
  import dmph_pkg::*;

  localparam int MAX_LEN        = 4096;
  localparam int IN_W           = 40;
  localparam int OUT_W          = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASE_ITEMS    = 115;
  localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
  localparam logic [HASH_W-1:0] HASH_ALL1  = '1;

  typedef struct packed {
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic [STAT_W-1:0] status;
    logic [12:0]       length;
  } hash_result_t;

  class hash_scoreboard;
    bit [HASH_W-1:0] mod_a, mod_b, base_a, base_b;
    bit [HASH_W-1:0] prefix_a[MAX_LEN+1];
    bit [HASH_W-1:0] prefix_b[MAX_LEN+1];
    bit [HASH_W-1:0] power_a[MAX_LEN+1];
    bit [HASH_W-1:0] power_b[MAX_LEN+1];
    int unsigned     str_len;
    hash_result_t    expected_hashes[$];
    int unsigned     mismatches;

    function new();
      mod_a      = MOD_A_RST;
      mod_b      = MOD_B_RST;
      base_a     = BASE_A_RST;
      base_b     = BASE_B_RST;
      prefix_a[0] = '0;
      prefix_b[0] = '0;
      power_a[0]  = HASH_W'(1);
      power_b[0]  = HASH_W'(1);
      str_len    = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_hashes.size();
    endfunction

    function int unsigned cur_length();
      return str_len;
    endfunction

    function void set_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
      case (idx)
        REG_MOD_A:  mod_a  = value[HASH_W-1:0];
        REG_MOD_B:  mod_b  = value[HASH_W-1:0];
        REG_BASE_A: base_a = value[HASH_W-1:0];
        REG_BASE_B: base_b = value[HASH_W-1:0];
        default: ;
      endcase
    endfunction

    // a zero modulus register behaves as modulus one
    function longint unsigned eff_mod(bit [HASH_W-1:0] m);
      return (m == 0) ? 64'd1 : 64'(m);
    endfunction

    function bit [HASH_W-1:0] mul_mod(bit [HASH_W-1:0] x, bit [HASH_W-1:0] y,
                                      longint unsigned m);
      longint unsigned p;
      p = 64'(x);
      p = p * y;
      return HASH_W'(p % m);
    endfunction

    // stored entries are reduced again by the current modulus
    function bit [HASH_W-1:0] range_hash(bit sel_b, int unsigned l, int unsigned r);
      longint unsigned m, hi, lo;
      m  = eff_mod(sel_b ? mod_b : mod_a);
      hi = (sel_b ? prefix_b[r] : prefix_a[r]) % m;
      lo = 64'(mul_mod(sel_b ? prefix_b[l-1] : prefix_a[l-1],
                       sel_b ? power_b[r-l+1] : power_a[r-l+1], m));
      return HASH_W'((hi + m - lo) % m);
    endfunction

    function void note_request(logic [IN_W-1:0] d);
      logic [REQ_W-1:0] req;
      logic [7:0]       ch;
      int unsigned      l, r, n;
      longint unsigned  ma, mb, t;
      hash_result_t     res;
      req = d[1:0];
      ch  = d[9:2];
      l   = 32'(d[22:10]);
      r   = 32'(d[35:23]);
      res = '0;
      case (req)
        REQ_APPEND: begin
          if (str_len >= MAX_LEN) begin
            res.status = ST_FULL;
          end else begin
            n  = str_len;
            ma = eff_mod(mod_a);
            mb = eff_mod(mod_b);
            power_a[n+1] = mul_mod(power_a[n], base_a, ma);
            power_b[n+1] = mul_mod(power_b[n], base_b, mb);
            t = 64'(mul_mod(prefix_a[n], base_a, ma));
            prefix_a[n+1] = HASH_W'((t + ch) % ma);
            t = 64'(mul_mod(prefix_b[n], base_b, mb));
            prefix_b[n+1] = HASH_W'((t + ch) % mb);
            str_len = n + 1;
          end
        end
        REQ_QUERY: begin
          if (l < 1 || l > r || r > str_len) begin
            res.status = ST_RANGE;
          end else begin
            res.hash_a = range_hash(1'b0, l, r);
            res.hash_b = range_hash(1'b1, l, r);
          end
        end
        REQ_CLEAR: str_len = 0;
        default: ;
      endcase
      res.length = str_len[12:0];
      expected_hashes.insert(expected_hashes.size(), res);
    endfunction

    function void check_response(logic [OUT_W-1:0] d);
      hash_result_t got, want;
      got.hash_a = d[29:0];
      got.hash_b = d[59:30];
      got.status = d[61:60];
      got.length = d[74:62];
      if (expected_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result hash_a=%0d hash_b=%0d status=%0d length=%0d",
                   $realtime, got.hash_a, got.hash_b, got.status, got.length);
        return;
      end
      want = expected_hashes.pop_front();
      if (got.hash_a !== want.hash_a || got.hash_b !== want.hash_b ||
          got.status !== want.status || got.length !== want.length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch exp a=%0d b=%0d st=%0d len=%0d, got a=%0d b=%0d st=%0d len=%0d",
                   $realtime, want.hash_a, want.hash_b, want.status, want.length,
                   got.hash_a, got.hash_b, got.status, got.length);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // req_type, char_code, left, right
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;  // hash_a, hash_b, status, length
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  hash_scoreboard sb = new();
  int             idle_cycles = 0;

  double_mod_prefix_hash_engine_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [IN_W-1:0] pack_request(logic [REQ_W-1:0] req, logic [7:0] ch,
                                                   logic [12:0] l, logic [12:0] r);
    return {4'b0, r, l, ch, req};
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, logic [7:0] ch,
                              logic [12:0] l, logic [12:0] r);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_request(req, ch, l, r);
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(in_tdata);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all_regs(logic [CFG_DW-1:0] ma, logic [CFG_DW-1:0] mb,
                              logic [CFG_DW-1:0] ba, logic [CFG_DW-1:0] bb);
    drain();
    write_reg(REG_MOD_A, ma);
    write_reg(REG_MOD_B, mb);
    write_reg(REG_BASE_A, ba);
    write_reg(REG_BASE_B, bb);
  endtask

  task automatic valid_query();
    int unsigned r, l;
    r = $urandom_range(1, sb.cur_length());
    l = $urandom_range(1, r);
    send_request(REQ_QUERY, 8'($urandom), 13'(l), 13'(r));
  endtask

  task automatic directed_items();
    send_request(REQ_QUERY, 8'h00, 13'd1, 13'd1);        // empty string
    send_request(REQ_APPEND, 8'h00, 13'd0, 13'd0);
    send_request(REQ_APPEND, 8'hFF, 13'h1FFF, 13'h1FFF);
    send_request(REQ_APPEND, 8'h80, 13'd0, 13'd0);
    send_request(REQ_APPEND, 8'h01, 13'd0, 13'd0);
    send_request(REQ_APPEND, 8'h7F, 13'd0, 13'd0);
    send_request(REQ_QUERY, 8'hFF, 13'd1, 13'd5);
    send_request(REQ_QUERY, 8'h00, 13'd1, 13'd1);
    send_request(REQ_QUERY, 8'h00, 13'd5, 13'd5);
    send_request(REQ_QUERY, 8'h00, 13'd2, 13'd4);
    send_request(REQ_QUERY, 8'h00, 13'd0, 13'd3);        // left below one
    send_request(REQ_QUERY, 8'h00, 13'd4, 13'd2);        // left past right
    send_request(REQ_QUERY, 8'h00, 13'd1, 13'd6);        // right past length
    send_request(REQ_QUERY, 8'h00, 13'h1FFF, 13'h1FFF);
    send_request(REQ_UNUSED, 8'hFF, 13'h1FFF, 13'h1FFF);
    send_request(REQ_APPEND, 8'h5A, 13'd0, 13'd0);
    send_request(REQ_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
    send_request(REQ_QUERY, 8'h00, 13'd1, 13'd1);
    send_request(REQ_APPEND, 8'hAA, 13'd0, 13'd0);
    send_request(REQ_QUERY, 8'h00, 13'd1, 13'd1);
    send_request(REQ_APPEND, 8'h3C, 13'd0, 13'd0);
    send_request(REQ_APPEND, 8'hC3, 13'd0, 13'd0);
  endtask

  // mostly appends and in-range queries, with some broken and noise items
  task automatic random_items(int n_items);
    int p;
    for (int i = 0; i < n_items; i++) begin
      p = $urandom_range(0, 99);
      if (p < 45 || (p < 85 && sb.cur_length() == 0))
        send_request(REQ_APPEND, 8'($urandom), 13'($urandom), 13'($urandom));
      else if (p < 85)
        valid_query();
      else if (p < 88)
        send_request(REQ_QUERY, 8'($urandom), 13'd0, 13'($urandom));
      else if (p < 91)
        send_request(REQ_QUERY, 8'($urandom),
                     13'($urandom_range(sb.cur_length() + 1, 8191)), 13'($urandom));
      else if (p < 93)
        send_request(REQ_QUERY, 8'($urandom), 13'($urandom_range(1, 4096)),
                     13'($urandom_range(sb.cur_length() + 1, 8191)));
      else if (p < 96)
        send_request(REQ_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
      else if (p < 98)
        send_request(REQ_UNUSED, 8'($urandom), 13'($urandom), 13'($urandom));
      else
        send_request(2'($urandom), 8'($urandom), 13'($urandom), 13'($urandom));
    end
  endtask

  task automatic random_phase(int n_items);
    if ($urandom_range(0, 1) == 0)
      send_request(REQ_CLEAR, 8'($urandom), 13'($urandom), 13'($urandom));
    random_items(n_items);
  endtask

  function automatic logic [CFG_DW-1:0] rand_mod();
    return {2'($urandom), 30'($urandom_range(2, HASH_ALL1))};
  endfunction

  function automatic logic [CFG_DW-1:0] rand_base();
    return {2'($urandom), 30'($urandom_range(1, HASH_ALL1))};
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    random_phase(PHASE_ITEMS);
    // widest moduli, bases at and just below them; string kept across the write
    set_all_regs({2'b00, HASH_ALL1}, {2'b00, HASH_ALL1},
                 {2'b00, HASH_ALL1 - 30'd1}, {2'b00, HASH_ALL1});
    repeat (6) valid_query();
    random_items(PHASE_ITEMS);
    set_all_regs(32'd2, 32'd3, {2'b11, 30'd1}, 32'd2);
    random_phase(PHASE_ITEMS);
    // zero modulus acts as one, so every hash is zero
    set_all_regs(32'd0, 32'd1, rand_base(), rand_base());
    random_phase(PHASE_ITEMS);
    for (int ph = 0; ph < 3; ph++) begin
      set_all_regs(rand_mod(), rand_mod(), rand_base(), rand_base());
      random_phase(PHASE_ITEMS);
    end
    set_all_regs({2'b00, MOD_A_RST}, {2'b00, MOD_B_RST},
                 {2'b00, BASE_A_RST}, {2'b00, BASE_B_RST});
    random_phase(PHASE_ITEMS);

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      gap = gap_len();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready)
      sb.check_response(out_tdata);
  end

  // watchdog: no transaction on any port for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

`default_nettype wire
